### design/wvc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wvc_pkg
// Shared types and constants for the waypoint velocity command block.
// ----------------------------------------------------------------------------
package wvc_pkg;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_GAIN_POS   = 3'd0;
    localparam logic [2:0] REG_GAIN_HEAD  = 3'd1;
    localparam logic [2:0] REG_GAIN_FINAL = 3'd2;
    localparam logic [2:0] REG_LIM_LIN    = 3'd3;
    localparam logic [2:0] REG_LIM_ANG    = 3'd4;
    localparam logic [2:0] REG_TOL_POS    = 3'd5;
    localparam logic [2:0] REG_TOL_HEAD   = 3'd6;

    // 1/K in Q30 (rotation start), 1/K in Q20 (distance scale)
    localparam logic [29:0] COS_START   = 30'd652032874;
    localparam logic [19:0] INV_K_Q20   = 20'd636751;
    // 2*pi and 0.15*2*pi in Q16
    localparam logic [18:0] TWO_PI_Q16  = 19'd411775;
    localparam logic [18:0] BLEND_Q16   = 19'd61766;

    // arctangent of 2^-i as 32-bit binary angle
    localparam logic [31:0] ATAN_TAB [0:31] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    // configuration register file contents
    typedef struct packed {
        logic [23:0] gain_pos;
        logic [23:0] gain_head;
        logic [23:0] gain_final;
        logic [30:0] lim_lin;
        logic [30:0] lim_ang;
        logic [30:0] tol_pos;
        logic [14:0] tol_head;
    } cfg_t;

    // item after classification, waiting for the back end
    typedef struct packed {
        logic signed [41:0] x0;     // right half-plane offset * 256
        logic signed [41:0] y0;
        logic               flip;   // offset was mirrored, bearing starts at pi
        logic signed [15:0] rh;     // robot heading
        logic signed [15:0] fe;     // final heading error
    } job_t;

    typedef enum logic [2:0] {
        S_IDLE, S_VEC, S_DIST, S_ROT, S_MUL1, S_MUL2, S_DONE
    } back_state_t;

endpackage

### design/waypoint_velocity_command.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_velocity_command
// Go-to-goal velocity command for a unicycle robot.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one item: robot pose and goal pose (Q16.16, binary angles).
//   m_* returns one item per input: linear speed, turn rate, at-goal flag.
//   Gains, limits and tolerances sit in APB registers at byte address 4*i;
//   a write of zero is stored as one. Write them only while the block idles.
// Timing:
//   The back end takes an item through the queue pop, one vectoring pass
//   and one rotation pass of a shared CORDIC stage, one step a cycle, a
//   distance multiply, the gain multiplies and the result load. A
//   two-entry queue takes new items while the back end is busy, and the
//   result register lets the back end start the next item while a result
//   waits.
// Reset:
//   aresetn (synchronous, low) empties the queue, drops m_valid and loads
//   the register defaults. When m_ready stays low the result holds, the
//   back end waits in its final state and the queue fills, then s_ready falls.
// ----------------------------------------------------------------------------
module waypoint_velocity_command import wvc_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_robot_x,
    input  logic signed [31:0] s_robot_y,
    input  logic signed [15:0] s_robot_heading,
    input  logic signed [31:0] s_goal_x,
    input  logic signed [31:0] s_goal_y,
    input  logic signed [15:0] s_goal_heading,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [30:0]        m_linear_speed,
    output logic signed [31:0] m_angular_speed,
    output logic               m_at_goal,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    cfg_t       cfg_reg;
    job_t       job, head;
    logic       q_full, q_empty, q_pop, push;
    logic [2:0] idx;

    assign pready  = 1'b1;
    assign idx     = paddr[4:2];
    assign s_ready = !q_full;
    assign push    = s_valid && !q_full;

    // register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_pos   <= 24'd65536;
            cfg_reg.gain_head  <= 24'd65536;
            cfg_reg.gain_final <= 24'd65536;
            cfg_reg.lim_lin    <= 31'd65536;
            cfg_reg.lim_ang    <= 31'd65536;
            cfg_reg.tol_pos    <= 31'd3277;
            cfg_reg.tol_head   <= 15'd182;
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                REG_GAIN_POS:   cfg_reg.gain_pos   <= (pwdata[23:0] == '0) ? 24'd1
                                                                          : pwdata[23:0];
                REG_GAIN_HEAD:  cfg_reg.gain_head  <= (pwdata[23:0] == '0) ? 24'd1
                                                                          : pwdata[23:0];
                REG_GAIN_FINAL: cfg_reg.gain_final <= (pwdata[23:0] == '0) ? 24'd1
                                                                          : pwdata[23:0];
                REG_LIM_LIN:    cfg_reg.lim_lin    <= (pwdata[30:0] == '0) ? 31'd1
                                                                          : pwdata[30:0];
                REG_LIM_ANG:    cfg_reg.lim_ang    <= (pwdata[30:0] == '0) ? 31'd1
                                                                          : pwdata[30:0];
                REG_TOL_POS:    cfg_reg.tol_pos    <= (pwdata[30:0] == '0) ? 31'd1
                                                                          : pwdata[30:0];
                REG_TOL_HEAD:   cfg_reg.tol_head   <= (pwdata[14:0] == '0) ? 15'd1
                                                                          : pwdata[14:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (idx)
            REG_GAIN_POS:   prdata = 32'(cfg_reg.gain_pos);
            REG_GAIN_HEAD:  prdata = 32'(cfg_reg.gain_head);
            REG_GAIN_FINAL: prdata = 32'(cfg_reg.gain_final);
            REG_LIM_LIN:    prdata = 32'(cfg_reg.lim_lin);
            REG_LIM_ANG:    prdata = 32'(cfg_reg.lim_ang);
            REG_TOL_POS:    prdata = 32'(cfg_reg.tol_pos);
            REG_TOL_HEAD:   prdata = 32'(cfg_reg.tol_head);
            default:        prdata = 32'd0;
        endcase
    end

    wvc_front u_front (
        .robot_x       (s_robot_x),
        .robot_y       (s_robot_y),
        .robot_heading (s_robot_heading),
        .goal_x        (s_goal_x),
        .goal_y        (s_goal_y),
        .goal_heading  (s_goal_heading),
        .job           (job)
    );

    wvc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (job),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (head)
    );

    wvc_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .q_empty         (q_empty),
        .q_head          (head),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_linear_speed  (m_linear_speed),
        .m_angular_speed (m_angular_speed),
        .m_at_goal       (m_at_goal)
    );
endmodule

### design/wvc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wvc_front
// Takes an input item, forms the pose offset and the final heading error.
// ----------------------------------------------------------------------------
module wvc_front import wvc_pkg::*; (
    input  logic signed [31:0] robot_x,
    input  logic signed [31:0] robot_y,
    input  logic signed [15:0] robot_heading,
    input  logic signed [31:0] goal_x,
    input  logic signed [31:0] goal_y,
    input  logic signed [15:0] goal_heading,
    output job_t               job
);
    logic signed [33:0] dx, dy, ndx, ndy;

    // offsets, mirrored into the right half plane for vectoring
    always_comb begin
        dx  = 34'(goal_x) - 34'(robot_x);
        dy  = 34'(goal_y) - 34'(robot_y);
        ndx = -dx;
        ndy = -dy;
        job.flip = dx[33];
        if (dx[33]) begin
            job.x0 = {ndx, 8'b0};
            job.y0 = {ndy, 8'b0};
        end else begin
            job.x0 = {dx, 8'b0};
            job.y0 = {dy, 8'b0};
        end
        job.rh = robot_heading;
        job.fe = goal_heading - robot_heading;  // wraps in 16 bits
    end
endmodule

### design/wvc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wvc_queue
// Two-entry queue of classified items between front and back end.
// ----------------------------------------------------------------------------
module wvc_queue import wvc_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic empty,
    output job_t head
);
    job_t       mem_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg;

    assign full  = cnt_reg == 2'd2;
    assign empty = cnt_reg == 2'd0;
    assign head  = mem_reg[rd_reg];

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wr_reg <= ~wr_reg;
            if (pop)  rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_reg] <= push_job;
    end
endmodule

### design/wvc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wvc_back
// Sequential CORDIC vectoring and rotation, gains, clamps, result register.
// ----------------------------------------------------------------------------
module wvc_back import wvc_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               q_empty,
    input  job_t               q_head,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [30:0]        m_linear_speed,
    output logic signed [31:0] m_angular_speed,
    output logic               m_at_goal
);
    localparam int CW = $clog2(CORDIC_STEPS);

    back_state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg;
    logic          out_free, out_load, last_step;

    logic signed [43:0] vx_reg, vy_reg, vx_sh, vy_sh;
    logic [31:0]        vz_reg, atan_v;
    logic signed [34:0] cx_reg, cy_reg, cz_reg, cx_sh, cy_sh;
    logic signed [15:0] rh_reg, fe_reg, he_reg, he_new;
    logic [63:0]        dprod;
    logic [15:0]        b16;
    logic [35:0]        dist_reg;
    logic               in_tol;
    logic signed [19:0] ct;
    logic [16:0]        cos_v, cos_reg;
    logic [43:0]        sp_reg;
    logic signed [40:0] pa_reg, pb_reg;
    logic [61:0]        linr_reg;
    logic signed [61:0] ta_reg, tb_reg, tsum;
    logic signed [29:0] ang_r;
    logic signed [32:0] ang_c, lim_s;
    logic [30:0]        lin_c;
    logic [16:0]        fe_abs;

    assign atan_v    = ATAN_TAB[5'(cnt_reg)];
    assign last_step = cnt_reg == CW'(CORDIC_STEPS - 1);
    assign out_free  = !m_valid || m_ready;
    assign in_tol    = dist_reg <= 36'(cfg.tol_pos);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (!q_empty) state_next = S_VEC;
            S_VEC:  if (last_step) state_next = S_DIST;
            S_DIST: state_next = S_ROT;
            S_ROT:  if (last_step) state_next = S_MUL1;
            S_MUL1: state_next = S_MUL2;
            S_MUL2: state_next = S_DONE;
            S_DONE: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        q_pop    = (state_reg == S_IDLE) && !q_empty;
        out_load = (state_reg == S_DONE) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            m_valid   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if ((state_reg == S_VEC || state_reg == S_ROT) && !last_step)
                cnt_reg <= cnt_reg + 1'b1;
            else
                cnt_reg <= '0;
            if (out_load)     m_valid <= 1'b1;
            else if (m_ready) m_valid <= 1'b0;
        end
    end

    // combinational pieces of the datapath
    always_comb begin
        vx_sh  = vx_reg >>> cnt_reg;
        vy_sh  = vy_reg >>> cnt_reg;
        cx_sh  = cx_reg >>> cnt_reg;
        cy_sh  = cy_reg >>> cnt_reg;
        dprod  = 64'(unsigned'(vx_reg)) * 64'(INV_K_Q20);
        b16    = 16'((vz_reg + 32'h8000) >> 16);
        he_new = signed'(b16) - rh_reg;
        ct     = 20'((cx_reg + 35'sd8192) >>> 14);
        if (he_reg >= 16'sd16384 || he_reg <= -16'sd16384 || ct < 0)
            cos_v = 17'd0;
        else if (ct > 20'sd65536)
            cos_v = 17'd65536;
        else
            cos_v = 17'(ct);
        tsum   = ta_reg + tb_reg + 62'sd2147483648;
        ang_r  = 30'(tsum >>> 32);
        lim_s  = signed'({2'b00, cfg.lim_ang});
        if (33'(ang_r) > lim_s)       ang_c = lim_s;
        else if (33'(ang_r) < -lim_s) ang_c = -lim_s;
        else                          ang_c = 33'(ang_r);
        if (in_tol)                          lin_c = 31'd0;
        else if (linr_reg > 62'(cfg.lim_lin)) lin_c = cfg.lim_lin;
        else                                 lin_c = 31'(linr_reg);
        fe_abs = fe_reg[15] ? 17'(-17'(fe_reg)) : 17'(fe_reg);
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                vx_reg <= 44'(q_head.x0);
                vy_reg <= 44'(q_head.y0);
                vz_reg <= q_head.flip ? 32'h80000000 : 32'h0;
                rh_reg <= q_head.rh;
                fe_reg <= q_head.fe;
            end
            S_VEC: begin
                if (!vy_reg[43]) begin
                    vx_reg <= vx_reg + vy_sh;
                    vy_reg <= vy_reg - vx_sh;
                    vz_reg <= vz_reg + atan_v;
                end else begin
                    vx_reg <= vx_reg - vy_sh;
                    vy_reg <= vy_reg + vx_sh;
                    vz_reg <= vz_reg - atan_v;
                end
            end
            S_DIST: begin
                dist_reg <= dprod[63:28] + 36'(dprod[27]);
                he_reg   <= he_new;
                cx_reg   <= 35'(COS_START);
                cy_reg   <= '0;
                cz_reg   <= 35'(signed'({he_new, 16'b0}));
            end
            S_ROT: begin
                if (!cz_reg[34]) begin
                    cx_reg <= cx_reg - cy_sh;
                    cy_reg <= cy_reg + cx_sh;
                    cz_reg <= cz_reg - 35'(atan_v);
                end else begin
                    cx_reg <= cx_reg + cy_sh;
                    cy_reg <= cy_reg - cx_sh;
                    cz_reg <= cz_reg + 35'(atan_v);
                end
            end
            S_MUL1: begin
                cos_reg <= cos_v;
                sp_reg  <= 44'((60'(cfg.gain_pos) * 60'(dist_reg)) >> 16);
                pa_reg  <= 41'(signed'({1'b0, cfg.gain_head})) * 41'(he_reg);
                pb_reg  <= 41'(signed'({1'b0, cfg.gain_final})) * 41'(fe_reg);
            end
            S_MUL2: begin
                linr_reg <= (62'(sp_reg) * 62'(cos_reg) + 62'd32768) >> 16;
                ta_reg   <= in_tol ? 62'sd0
                                   : 62'(pa_reg) * 62'(signed'({1'b0, TWO_PI_Q16}));
                tb_reg   <= 62'(pb_reg) *
                            62'(signed'({1'b0, in_tol ? TWO_PI_Q16 : BLEND_Q16}));
            end
            S_DONE: begin
                if (out_load) begin
                    m_linear_speed  <= lin_c;
                    m_angular_speed <= 32'(ang_c);
                    m_at_goal       <= in_tol && (fe_abs <= 17'(cfg.tol_head));
                end
            end
            default: ;
        endcase
    end
endmodule
